// File: src/mpfc_pkg.sv
// ----------------------------------------------------------------------------
// mpfc_pkg
// Shared types, codes and constants of the MAC pair flow counter: the request
// and response words, the controller command and status groups, and the
// register map.
// ----------------------------------------------------------------------------
package mpfc_pkg;

  localparam int unsigned MAX_FLOWS_DEF   = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned MAC_W    = 48;
  localparam int unsigned KEY_W    = 2 * MAC_W;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned PKT_W    = 32;
  localparam int unsigned ECOUNT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-1:0] ADDR_TABLE_LIMIT = '0;

  typedef enum logic [1:0] {
    REQ_FRAME = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_COUNTED    = 3'd0,
    ST_NEW        = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_CLEARED    = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [IDX_W-1:0]  read_index;
  } req_word_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     entry_index;
    logic [PKT_W-1:0]     packet_count;
    logic [MAC_W-1:0]     dst_mac_out;
    logic [MAC_W-1:0]     src_mac_out;
    logic [ECOUNT_W-1:0]  entry_count;
  } rsp_word_t;

  typedef struct packed {
    logic    accept;
    logic    scan;
    logic    hit_cap;
    logic    hit_upd;
    logic    insert;
    logic    read_idx;
    logic    rd_req;
    logic    rd_cap;
    logic    clear;
    logic    out_load;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      table_empty;
    logic      read_hit;
    logic      hit;
    logic      scan_end;
    logic      can_insert;
    logic      out_free;
  } ctrl_sts_t;

endpackage

// File: src/mpfc_ram.sv
// ----------------------------------------------------------------------------
// mpfc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mpfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mpfc_datapath.sv
// ----------------------------------------------------------------------------
// mpfc_datapath
// Key and count stores, fill counter, scan pipeline, limit register and the
// response register of the flow counter.
// ----------------------------------------------------------------------------
module mpfc_datapath #(
  parameter int unsigned MAX_FLOWS   = mpfc_pkg::MAX_FLOWS_DEF,
  parameter int unsigned COUNT_WIDTH = mpfc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpfc_pkg::req_word_t           req_word,
  input  logic                          cfg_we,
  input  logic [mpfc_pkg::LIMIT_W-1:0]  cfg_limit,
  output logic [mpfc_pkg::LIMIT_W-1:0]  table_limit,
  input  mpfc_pkg::ctrl_cmd_t           cmd,
  output mpfc_pkg::ctrl_sts_t           sts,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output mpfc_pkg::rsp_word_t           rsp_word
);

  localparam int unsigned ADDR_W = $clog2(MAX_FLOWS);
  localparam int unsigned FILL_W = $clog2(MAX_FLOWS + 1);
  localparam int unsigned XW     = (FILL_W > mpfc_pkg::LIMIT_W) ? FILL_W : mpfc_pkg::LIMIT_W;
  localparam int unsigned KEY_W  = mpfc_pkg::KEY_W;
  localparam int unsigned IDX_W  = mpfc_pkg::IDX_W;

  mpfc_pkg::req_type_t       req_q;
  logic [KEY_W-1:0]          key_q;
  logic [IDX_W-1:0]          ridx_q;
  logic [FILL_W-1:0]         filled;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      issue_done;
  logic                      cmp_valid;
  logic [ADDR_W-1:0]         cmp_idx;
  logic [ADDR_W-1:0]         hit_idx;
  logic [COUNT_WIDTH-1:0]    hit_cnt;
  logic [COUNT_WIDTH-1:0]    sat_cnt;
  logic [IDX_W-1:0]          res_idx;
  logic [COUNT_WIDTH-1:0]    res_cnt;
  logic [mpfc_pkg::MAC_W-1:0] res_dst;
  logic [mpfc_pkg::MAC_W-1:0] res_src;

  logic [XW-1:0]             eff_limit;
  logic [XW-1:0]             ridx_x;
  logic [FILL_W-1:0]         last_idx;
  logic [ADDR_W-1:0]         ins_addr;
  logic [ADDR_W-1:0]         key_raddr;
  logic [KEY_W-1:0]          key_rdata;
  logic [COUNT_WIDTH-1:0]    cnt_rdata;
  logic                      cnt_we;
  logic [ADDR_W-1:0]         cnt_waddr;
  logic [COUNT_WIDTH-1:0]    cnt_wdata;
  logic                      issue;

  assign eff_limit = (XW'(table_limit) > XW'(MAX_FLOWS)) ? XW'(MAX_FLOWS) : XW'(table_limit);
  assign ridx_x    = XW'(ridx_q);
  assign last_idx  = filled - FILL_W'(1);
  assign ins_addr  = ADDR_W'(filled);
  assign key_raddr = cmd.rd_req ? ADDR_W'(ridx_x) : rd_addr;
  assign issue     = cmd.scan && !issue_done;
  assign sat_cnt   = (hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_WIDTH'(1);

  assign cnt_we    = cmd.insert || cmd.hit_upd;
  assign cnt_waddr = cmd.insert ? ins_addr : hit_idx;
  assign cnt_wdata = cmd.insert ? COUNT_WIDTH'(1) : sat_cnt;

  mpfc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_FLOWS)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (ins_addr),
    .wdata (key_q),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  mpfc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_FLOWS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (key_raddr),
    .rdata (cnt_rdata)
  );

  always_comb begin
    sts.req_type    = req_q;
    sts.table_empty = (filled == '0);
    sts.read_hit    = (ridx_x < XW'(filled));
    sts.hit         = cmp_valid && (key_rdata == key_q);
    sts.scan_end    = cmp_valid && (FILL_W'(cmp_idx) == last_idx);
    sts.can_insert  = (XW'(filled) < eff_limit);
    sts.out_free    = !rsp_valid || !rsp_stall;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled      <= '0;
      table_limit <= mpfc_pkg::LIMIT_RESET;
      issue_done  <= 1'b0;
      cmp_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_limit <= cfg_limit;
      end
      if (cfg_we || cmd.clear) begin
        filled <= '0;
      end else if (cmd.insert) begin
        filled <= filled + FILL_W'(1);
      end
      if (cmd.accept) begin
        issue_done <= 1'b0;
      end else if (issue && (FILL_W'(rd_addr) == last_idx)) begin
        issue_done <= 1'b1;
      end
      cmp_valid <= issue;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q   <= req_word.req_type;
      key_q   <= {req_word.dst_mac, req_word.src_mac};
      ridx_q  <= req_word.read_index;
      rd_addr <= '0;
    end else if (issue) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
    if (issue) begin
      cmp_idx <= rd_addr;
    end
    if (cmd.hit_cap) begin
      hit_idx <= cmp_idx;
      hit_cnt <= cnt_rdata;
    end
    if (cmd.hit_upd) begin
      res_idx <= IDX_W'(hit_idx);
      res_cnt <= sat_cnt;
    end else if (cmd.insert) begin
      res_idx <= IDX_W'(ins_addr);
      res_cnt <= COUNT_WIDTH'(1);
    end else if (cmd.read_idx) begin
      res_idx <= ridx_q;
    end else if (cmd.rd_cap) begin
      res_cnt <= cnt_rdata;
      res_dst <= key_rdata[KEY_W-1:mpfc_pkg::MAC_W];
      res_src <= key_rdata[mpfc_pkg::MAC_W-1:0];
    end
    if (cmd.out_load) begin
      rsp_word.status       <= cmd.code;
      rsp_word.entry_index  <= '0;
      rsp_word.packet_count <= '0;
      rsp_word.dst_mac_out  <= '0;
      rsp_word.src_mac_out  <= '0;
      rsp_word.entry_count  <= mpfc_pkg::ECOUNT_W'(filled);
      case (cmd.code) inside
        mpfc_pkg::ST_COUNTED, mpfc_pkg::ST_NEW: begin
          rsp_word.entry_index  <= res_idx;
          rsp_word.packet_count <= mpfc_pkg::PKT_W'(res_cnt);
        end
        mpfc_pkg::ST_READ_OK: begin
          rsp_word.entry_index  <= res_idx;
          rsp_word.packet_count <= mpfc_pkg::PKT_W'(res_cnt);
          rsp_word.dst_mac_out  <= res_dst;
          rsp_word.src_mac_out  <= res_src;
        end
        mpfc_pkg::ST_READ_EMPTY: begin
          rsp_word.entry_index <= res_idx;
        end
        default: begin
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(filled) <= XW'(MAX_FLOWS))
    else $error("fill count beyond table depth");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (XW'(filled) < eff_limit))
    else $error("insert with the table at its limit");

  a_cmp_filled: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (FILL_W'(cmp_idx) < filled))
    else $error("compare of an unfilled entry");

endmodule

// File: src/mpfc_ctrl.sv
// ----------------------------------------------------------------------------
// mpfc_ctrl
// Sequencer of the flow counter: decodes a request, clears the table, reads an
// entry or scans and updates or appends one, and loads the response register.
// ----------------------------------------------------------------------------
module mpfc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mpfc_pkg::ctrl_sts_t sts,
  output mpfc_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_RWAIT,
    S_DONE
  } state_t;

  state_t            state;
  state_t            state_next;
  mpfc_pkg::status_t code;
  mpfc_pkg::status_t code_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.req_type)
          mpfc_pkg::REQ_FRAME: begin
            state_next = sts.table_empty ? S_MISS : S_SCAN;
          end
          mpfc_pkg::REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            code_next  = mpfc_pkg::ST_CLEARED;
            state_next = S_DONE;
          end
          mpfc_pkg::REQ_READ: begin
            cmd.read_idx = 1'b1;
            if (sts.read_hit) begin
              cmd.rd_req = 1'b1;
              state_next = S_RWAIT;
            end else begin
              code_next  = mpfc_pkg::ST_READ_EMPTY;
              state_next = S_DONE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.hit_cap = 1'b1;
          state_next  = S_HIT;
        end else if (sts.scan_end) begin
          state_next = S_MISS;
        end
      end
      S_HIT: begin
        cmd.hit_upd = 1'b1;
        code_next   = mpfc_pkg::ST_COUNTED;
        state_next  = S_DONE;
      end
      S_MISS: begin
        if (sts.can_insert) begin
          cmd.insert = 1'b1;
          code_next  = mpfc_pkg::ST_NEW;
        end else begin
          code_next = mpfc_pkg::ST_DROPPED;
        end
        state_next = S_DONE;
      end
      S_RWAIT: begin
        cmd.rd_cap = 1'b1;
        code_next  = mpfc_pkg::ST_READ_OK;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= mpfc_pkg::ST_COUNTED;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  a_hit_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_HIT) |-> $past(sts.hit))
    else $error("update entered without a key match");

  a_port_users: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan, cmd.rd_req, cmd.insert}))
    else $error("store port claimed twice");

  a_load_code: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE))
    else $error("response loaded without return to idle");

endmodule

// File: src/mac_pair_flow_counter.sv
// ----------------------------------------------------------------------------
// mac_pair_flow_counter
// Flow table keyed by a destination and source MAC pair, with saturating
// packet counts, table clear, entry read-back and a configurable entry limit.
//
//   Channel   Direction  Handshake            Word
//   request   in         req_valid/req_stall  req_word (mpfc_pkg::req_word_t)
//   response  out        rsp_valid/rsp_stall  rsp_word (mpfc_pkg::rsp_word_t)
//   config    in         APB                  table_limit at byte address 0
//
// A frame's scan walks the filled entries, up to the first match, at one entry
// per cycle through the key store read port; clear and read requests do not
// scan. No new request is accepted until the last response is loaded.
// Reset empties the table and restores the limit to 50; the stores are not
// cleared, as only filled entries are ever read.
// A stalled response holds the next request in its final state until taken.
// ----------------------------------------------------------------------------
module mac_pair_flow_counter #(
  parameter int unsigned MAX_FLOWS   = mpfc_pkg::MAX_FLOWS_DEF,
  parameter int unsigned COUNT_WIDTH = mpfc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  mpfc_pkg::req_word_t           req_word,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output mpfc_pkg::rsp_word_t           rsp_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpfc_pkg::PADDR_W-1:0]  paddr,
  input  logic [mpfc_pkg::PDATA_W-1:0]  pwdata,
  output logic [mpfc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  mpfc_pkg::ctrl_cmd_t                 cmd;
  mpfc_pkg::ctrl_sts_t                 sts;
  logic                                cfg_we;
  logic [mpfc_pkg::LIMIT_W-1:0]        table_limit;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == mpfc_pkg::ADDR_TABLE_LIMIT);
  assign prdata = (paddr == mpfc_pkg::ADDR_TABLE_LIMIT) ?
                  mpfc_pkg::PDATA_W'(table_limit) : '0;

  mpfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpfc_datapath #(
    .MAX_FLOWS   (MAX_FLOWS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_word    (req_word),
    .cfg_we      (cfg_we),
    .cfg_limit   (pwdata[mpfc_pkg::LIMIT_W-1:0]),
    .table_limit (table_limit),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_word    (rsp_word)
  );

endmodule
